[rtl/assert_macros.svh]
// Assertion macros shared by the partitioner RTL.
// Included by every module that carries concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, off while reset is asserted.
`define SGPA_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("sgpa check failed");

// Clocked check that also holds during reset.
`define SGPA_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("sgpa check failed");

`endif

[rtl/sgpa_pkg.sv]
// Package for the streaming graph partitioner: word types, widths, defaults.
// No dependencies; used by every module in rtl/.
package sgpa_pkg;

  localparam int PARTITIONS_DEF   = 8;
  localparam int MAX_VERTICES_DEF = 65536;
  localparam int COUNT_WIDTH_DEF  = 16;

  localparam int VID_W      = 16;
  localparam int OUT_PART_W = 3;
  localparam int EDGE_W     = 16;
  localparam int ALPHA_W    = 16;
  localparam int SIZE_W     = 17;
  // square root input is size or size+1, taken times 2^32
  localparam int SQ_IN_W    = SIZE_W + 1;
  localparam int SQ_ARG_W   = SQ_IN_W + 32;
  localparam int ROOT_W     = SQ_ARG_W / 2;
  localparam int COST_W     = 27;

  localparam logic [ALPHA_W-1:0] ALPHA_RESET = 16'd128;
  localparam logic [SIZE_W-1:0]  SIZE_MAX    = {SIZE_W{1'b1}};
  // growth cost of an empty partition: 1^1.5 in Q.16
  localparam logic [COST_W-1:0]  COST_RESET  = 27'd65536;

  localparam logic KIND_NEIGHBOR = 1'b0;
  localparam logic KIND_PLACE    = 1'b1;

  typedef struct packed {
    logic             kind;
    logic [VID_W-1:0] vertex_id;
  } in_word_t;

  typedef struct packed {
    logic [VID_W-1:0]      placed_vertex;
    logic [OUT_PART_W-1:0] chosen_partition;
    logic [EDGE_W-1:0]     edges_added;
    logic                  was_seed;
  } out_word_t;

endpackage

[rtl/sgpa_vmap.sv]
// Vertex-to-partition map: single-port synchronous RAM with a clear sweep after reset.
// Depends on sgpa_pkg and assert_macros.svh.
module sgpa_vmap #(
  parameter int MAX_VERTICES = sgpa_pkg::MAX_VERTICES_DEF,
  parameter int ENTRY_W      = 4
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            rd_en,
  input  logic                            wr_en,
  input  logic [$clog2(MAX_VERTICES)-1:0] addr,
  input  logic [ENTRY_W-1:0]              wdata,
  output logic [ENTRY_W-1:0]              rdata,
  output logic                            clearing
);
  import sgpa_pkg::*;
`include "assert_macros.svh"

  localparam int AW = $clog2(MAX_VERTICES);

  logic [ENTRY_W-1:0] mem [MAX_VERTICES];
  logic [ENTRY_W-1:0] rdata_r;
  logic               clr_active_r;
  logic [AW-1:0]      clr_addr_r;

  // clear sweep control, one entry a cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_addr_r   <= '0;
    end else if (clr_active_r) begin
      clr_addr_r <= clr_addr_r + AW'(1);
      if (clr_addr_r == AW'(MAX_VERTICES - 1)) clr_active_r <= 1'b0;
    end
  end

  // storage, registered read
  always_ff @(posedge clk) begin
    if (clr_active_r) mem[clr_addr_r] <= '0;
    else if (wr_en) mem[addr] <= wdata;
    if (rd_en) rdata_r <= mem[addr];
  end

  assign rdata    = rdata_r;
  assign clearing = clr_active_r;

  `SGPA_ASSERT(a_no_access_while_clearing, clk, rst_n, clr_active_r |-> !wr_en && !rd_en)

endmodule

[rtl/sgpa_isqrt.sv]
// Iterative integer square root of x*2^32, two radicand bits per cycle.
// Depends on sgpa_pkg and assert_macros.svh.
module sgpa_isqrt (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [sgpa_pkg::SQ_IN_W-1:0] x,
  output logic                         done,
  output logic [sgpa_pkg::ROOT_W-1:0]  root
);
  import sgpa_pkg::*;
`include "assert_macros.svh"

  localparam int CNT_W = $clog2(ROOT_W + 1);
  localparam int REM_W = ROOT_W + 1;

  logic                busy_r;
  logic                done_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [SQ_ARG_W-1:0] arg_r;
  logic [REM_W-1:0]    rem_r;
  logic [ROOT_W-1:0]   root_r;

  logic [REM_W+1:0]    rem_sh;
  logic [REM_W+1:0]    trial;
  logic                take;

  // one result bit per step
  always_comb begin
    rem_sh = {rem_r, arg_r[SQ_ARG_W-1 -: 2]};
    trial  = {2'b00, root_r[ROOT_W-2:0], 2'b01};
    take   = (rem_sh >= trial);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(ROOT_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start && !busy_r) begin
      arg_r  <= {x, 32'b0};
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      arg_r <= {arg_r[SQ_ARG_W-3:0], 2'b00};
      if (take) begin
        rem_r  <= REM_W'(rem_sh - trial);
        root_r <= {root_r[ROOT_W-2:0], 1'b1};
      end else begin
        rem_r  <= REM_W'(rem_sh);
        root_r <= {root_r[ROOT_W-2:0], 1'b0};
      end
    end
  end

  assign done = done_r;
  assign root = root_r;

  `SGPA_ASSERT(a_done_ends_run, clk, rst_n, done_r |-> !busy_r && $past(busy_r))

endmodule

[rtl/streaming_graph_partition_assign.sv]
// Streaming graph partitioner (greedy score placement into PARTITIONS partitions).
// A neighbor word does a map RAM read, then a neighbor count update. A place word is
// scored against every partition unless it is a seed, then committed; after that the
// iterative square root runs twice to refresh the growth cost of the partition that
// grew, unless its size is saturated. After reset the vertex map RAM is swept clear,
// one entry a cycle, and no input word is taken until the sweep ends; config writes
// are taken.
// Depends on sgpa_pkg, sgpa_vmap, sgpa_isqrt and assert_macros.svh.
module streaming_graph_partition_assign #(
  parameter int PARTITIONS   = sgpa_pkg::PARTITIONS_DEF,
  parameter int MAX_VERTICES = sgpa_pkg::MAX_VERTICES_DEF,
  parameter int COUNT_WIDTH  = sgpa_pkg::COUNT_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  sgpa_pkg::in_word_t            in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output sgpa_pkg::out_word_t           out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [sgpa_pkg::ALPHA_W-1:0]  cfg_data
);
  import sgpa_pkg::*;
`include "assert_macros.svh"

  localparam int PW      = $clog2(PARTITIONS);
  localparam int SCW     = $clog2(PARTITIONS + 1);
  localparam int AW      = $clog2(MAX_VERTICES);
  localparam int ENTRY_W = PW + 1;
  localparam int PROD_W  = ALPHA_W + COST_W;
  localparam int PEN_W   = PROD_W - 8;
  localparam int SCORE_W = ((COUNT_WIDTH + 16) > PEN_W ? (COUNT_WIDTH + 16) : PEN_W) + 1;
  localparam int MUL_W   = SQ_IN_W + ROOT_W;

  typedef enum logic [3:0] {
    ST_IDLE, ST_NBR, ST_SCAN, ST_DRAIN, ST_COMMIT,
    ST_SQH0, ST_SQH, ST_SQL0, ST_SQL, ST_MUL, ST_WB
  } state_t;

  state_t                  state_r;
  logic [ALPHA_W-1:0]      alpha_r;
  logic [SCW-1:0]          seed_cnt_r;
  logic [COUNT_WIDTH-1:0]  count_r [PARTITIONS];
  logic [SIZE_W-1:0]       size_r  [PARTITIONS];
  logic [COST_W-1:0]       cost_r  [PARTITIONS];

  logic [VID_W-1:0]        vid_r;
  logic                    vid_ok_r;
  logic [PW-1:0]           best_r;
  logic                    seed_r;
  logic [PW-1:0]           scan_idx_r;
  logic                    s1_v_r;
  logic [PW-1:0]           s1_idx_r;
  logic [PEN_W-1:0]        s1_pen_r;
  logic [COUNT_WIDTH-1:0]  s1_cnt_r;
  logic signed [SCORE_W-1:0] best_score_r;
  logic [SIZE_W-1:0]       new_size_r;
  logic [ROOT_W-1:0]       r_hi_r;
  logic [ROOT_W-1:0]       r_lo_r;
  logic [MUL_W-1:0]        prod_hi_r;
  logic [MUL_W-1:0]        prod_lo_r;
  logic                    out_valid_r;
  out_word_t               out_data_r;

  logic                    in_fire;
  logic                    out_free;
  logic                    commit_fire;
  logic                    map_clearing;
  logic                    map_rd;
  logic                    map_wr;
  logic [AW-1:0]           map_addr;
  logic [ENTRY_W-1:0]      map_rdata;
  logic                    in_ok;
  logic [AW+VID_W-1:0]     in_ext;
  logic [AW+VID_W-1:0]     vid_ext;
  logic                    sq_start;
  logic [SQ_IN_W-1:0]      sq_x;
  logic                    sq_done;
  logic [ROOT_W-1:0]       sq_root;
  logic [PROD_W-1:0]       pen_full;
  logic signed [SCORE_W-1:0] s1_score;
  logic [COUNT_WIDTH-1:0]  best_cnt;
  logic [COUNT_WIDTH+EDGE_W-1:0] added_ext;
  logic [EDGE_W-1:0]       added_sat;
  logic [PW+OUT_PART_W-1:0] best_ext;
  logic [PW-1:0]           nbr_part;

  // handshakes
  assign in_stall    = (state_r != ST_IDLE) || map_clearing;
  assign in_fire     = in_valid && !in_stall;
  assign out_free    = !out_valid_r || !out_stall;
  assign commit_fire = (state_r == ST_COMMIT) && out_free;
  assign cfg_ready   = 1'b1;
  assign out_valid   = out_valid_r;
  assign out_data    = out_data_r;

  // id range checks and map addressing
  assign in_ext   = {{AW{1'b0}}, in_data.vertex_id};
  assign vid_ext  = {{AW{1'b0}}, vid_r};
  assign in_ok    = in_ext < (AW+VID_W)'(MAX_VERTICES);
  assign map_rd   = in_fire && (in_data.kind == KIND_NEIGHBOR) && in_ok;
  assign map_wr   = commit_fire && vid_ok_r;
  assign map_addr = (state_r == ST_COMMIT) ? vid_ext[AW-1:0] : in_ext[AW-1:0];
  assign nbr_part = map_rdata[PW-1:0];

  sgpa_vmap #(
    .MAX_VERTICES (MAX_VERTICES),
    .ENTRY_W      (ENTRY_W)
  ) u_vmap (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (map_rd),
    .wr_en    (map_wr),
    .addr     (map_addr),
    .wdata    ({1'b1, best_r}),
    .rdata    (map_rdata),
    .clearing (map_clearing)
  );

  // square root of the grown partition's size and size+1
  assign sq_start = (state_r == ST_SQH0) || (state_r == ST_SQL0);
  assign sq_x     = (state_r == ST_SQH0) ? (SQ_IN_W'(new_size_r) + SQ_IN_W'(1))
                                         : SQ_IN_W'(new_size_r);

  sgpa_isqrt u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sq_start),
    .x     (sq_x),
    .done  (sq_done),
    .root  (sq_root)
  );

  // score of the partition in the second scan stage
  assign pen_full = alpha_r * cost_r[scan_idx_r];
  assign s1_score = $signed(SCORE_W'({s1_cnt_r, 16'b0})) - $signed(SCORE_W'(s1_pen_r));

  // result fields
  assign best_cnt  = count_r[best_r];
  assign added_ext = {{EDGE_W{1'b0}}, best_cnt};
  assign added_sat = seed_r ? '0 :
                     (added_ext > (COUNT_WIDTH+EDGE_W)'({EDGE_W{1'b1}})) ? {EDGE_W{1'b1}}
                                                                          : added_ext[EDGE_W-1:0];
  assign best_ext  = {{OUT_PART_W{1'b0}}, best_r};

  // config register
  always_ff @(posedge clk) begin
    if (!rst_n) alpha_r <= ALPHA_RESET;
    else if (cfg_valid && cfg_ready) alpha_r <= cfg_data;
  end

  // sequencer and partition state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      seed_cnt_r  <= '0;
      out_valid_r <= 1'b0;
      s1_v_r      <= 1'b0;
      for (int p = 0; p < PARTITIONS; p++) begin
        count_r[p] <= '0;
        size_r[p]  <= '0;
        cost_r[p]  <= COST_RESET;
      end
    end else begin
      // result word taken and no new one loaded
      if (out_valid_r && !out_stall && !commit_fire) out_valid_r <= 1'b0;
      s1_v_r <= (state_r == ST_SCAN);

      // scan stage two: compare, lower index wins ties
      if (s1_v_r) begin
        if (s1_idx_r == '0 || s1_score > best_score_r) begin
          best_score_r <= s1_score;
          best_r       <= s1_idx_r;
        end
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            vid_r    <= in_data.vertex_id;
            vid_ok_r <= in_ok;
            if (in_data.kind == KIND_NEIGHBOR) begin
              state_r <= in_ok ? ST_NBR : ST_IDLE;
            end else if (seed_cnt_r < SCW'(PARTITIONS)) begin
              best_r     <= seed_cnt_r[PW-1:0];
              seed_r     <= 1'b1;
              seed_cnt_r <= seed_cnt_r + SCW'(1);
              state_r    <= ST_COMMIT;
            end else begin
              seed_r     <= 1'b0;
              scan_idx_r <= '0;
              state_r    <= ST_SCAN;
            end
          end
        end
        ST_NBR: begin
          if (map_rdata[ENTRY_W-1] && count_r[nbr_part] != {COUNT_WIDTH{1'b1}})
            count_r[nbr_part] <= count_r[nbr_part] + COUNT_WIDTH'(1);
          state_r <= ST_IDLE;
        end
        ST_SCAN: begin
          s1_idx_r <= scan_idx_r;
          s1_pen_r <= pen_full[PROD_W-1:8];
          s1_cnt_r <= count_r[scan_idx_r];
          if (scan_idx_r == PW'(PARTITIONS - 1)) state_r <= ST_DRAIN;
          else scan_idx_r <= scan_idx_r + PW'(1);
        end
        ST_DRAIN: begin
          state_r <= ST_COMMIT;
        end
        ST_COMMIT: begin
          if (out_free) begin
            out_valid_r                 <= 1'b1;
            out_data_r.placed_vertex    <= vid_r;
            out_data_r.chosen_partition <= best_ext[OUT_PART_W-1:0];
            out_data_r.edges_added      <= added_sat;
            out_data_r.was_seed         <= seed_r;
            for (int p = 0; p < PARTITIONS; p++) count_r[p] <= '0;
            if (size_r[best_r] != SIZE_MAX) begin
              size_r[best_r] <= size_r[best_r] + SIZE_W'(1);
              new_size_r     <= size_r[best_r] + SIZE_W'(1);
              state_r        <= ST_SQH0;
            end else begin
              state_r <= ST_IDLE;
            end
          end
        end
        ST_SQH0: state_r <= ST_SQH;
        ST_SQH: begin
          if (sq_done) begin
            r_hi_r  <= sq_root;
            state_r <= ST_SQL0;
          end
        end
        ST_SQL0: state_r <= ST_SQL;
        ST_SQL: begin
          if (sq_done) begin
            r_lo_r  <= sq_root;
            state_r <= ST_MUL;
          end
        end
        ST_MUL: begin
          prod_hi_r <= (SQ_IN_W'(new_size_r) + SQ_IN_W'(1)) * r_hi_r;
          prod_lo_r <= SQ_IN_W'(new_size_r) * r_lo_r;
          state_r   <= ST_WB;
        end
        ST_WB: begin
          cost_r[best_r] <= COST_W'(prod_hi_r - prod_lo_r);
          state_r        <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  `SGPA_ASSERT(a_pending_word_held, clk, rst_n,
    (state_r == ST_COMMIT && out_valid_r && out_stall) |=> state_r == ST_COMMIT)
  `SGPA_ASSERT(a_seed_count_bound, clk, rst_n, seed_cnt_r <= SCW'(PARTITIONS))

endmodule
